// ===== hdl/ksh_pkg.sv =====
// ----------------------------------------------------------------------------
// ksh_pkg
// Shared types, constants and round functions for the keyed SipHash-1-2 unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ksh_pkg;

  // SipHash initialization constants.
  localparam logic [63:0] SIP_C0 = 64'h736f6d6570736575;
  localparam logic [63:0] SIP_C1 = 64'h646f72616e646f6d;
  localparam logic [63:0] SIP_C2 = 64'h6c7967656e657261;
  localparam logic [63:0] SIP_C3 = 64'h7465646279746573;

  // Value folded into v2 before finalization.
  localparam logic [7:0] FINAL_XOR = 8'hff;

  // Byte lane that completes a 64-bit word.
  localparam logic [2:0] LAST_LANE = 3'd7;

  // Configuration register indexes.
  localparam logic [1:0] REG_KEY_LOW   = 2'd0;
  localparam logic [1:0] REG_KEY_HIGH  = 2'd1;
  localparam logic [1:0] REG_FOLD_CASE = 2'd2;

  // The four chaining words of SipHash.
  typedef struct packed {
    logic [63:0] v0;
    logic [63:0] v1;
    logic [63:0] v2;
    logic [63:0] v3;
  } sip_state_t;

  // Rotate left by a constant amount.
  function automatic logic [63:0] rotl(input logic [63:0] x, input int n);
    return (x << n) | (x >> (64 - n));
  endfunction

  // Chaining words at the start of a message.
  function automatic sip_state_t sip_init(input logic [63:0] k0, input logic [63:0] k1);
    sip_state_t s;
    s.v0 = SIP_C0 ^ k0;
    s.v1 = SIP_C1 ^ k1;
    s.v2 = SIP_C2 ^ k0;
    s.v3 = SIP_C3 ^ k1;
    return s;
  endfunction

  // One SipRound: two add-rotate-xor half rounds.
  function automatic sip_state_t sip_round(input sip_state_t s);
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] d;
    sip_state_t  r;
    a = s.v0;
    b = s.v1;
    c = s.v2;
    d = s.v3;
    a = a + b; b = rotl(b, 13); b = b ^ a; a = rotl(a, 32);
    c = c + d; d = rotl(d, 16); d = d ^ c;
    a = a + d; d = rotl(d, 21); d = d ^ a;
    c = c + b; b = rotl(b, 17); b = b ^ c; c = rotl(c, 32);
    r.v0 = a;
    r.v1 = b;
    r.v2 = c;
    r.v3 = d;
    return r;
  endfunction

  // Absorb one 64-bit message word with a single round.
  function automatic sip_state_t sip_compress(input sip_state_t s, input logic [63:0] w);
    sip_state_t t;
    t    = s;
    t.v3 = t.v3 ^ w;
    t    = sip_round(t);
    t.v0 = t.v0 ^ w;
    return t;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/ksh_absorb.sv =====
// ----------------------------------------------------------------------------
// ksh_absorb
// Folds case, buffers one byte into the partial word and compresses the word
// once its eighth byte arrives.
// ----------------------------------------------------------------------------
`default_nettype none

module ksh_absorb (
  input  ksh_pkg::sip_state_t state_in,
  input  logic [55:0]         partial_in,
  input  logic [7:0]          length_in,
  input  logic [7:0]          data_byte,
  input  logic                byte_present,
  input  logic                fold_case,
  output ksh_pkg::sip_state_t state_out,
  output logic [55:0]         partial_out,
  output logic [7:0]          length_out
);

  logic [7:0] byte_fold;
  logic [2:0] lane;

  // Map uppercase ASCII to lowercase when case folding is on.
  always_comb begin
    byte_fold = data_byte;
    if (fold_case && (data_byte inside {[8'h41:8'h5a]})) begin
      byte_fold = data_byte + 8'h20;
    end
  end

  assign lane = length_in[2:0];

  // Insert the byte into its lane, or finish and compress the word.
  always_comb begin
    state_out   = state_in;
    partial_out = partial_in;
    if (byte_present) begin
      if (lane == ksh_pkg::LAST_LANE) begin
        state_out   = ksh_pkg::sip_compress(state_in, {byte_fold, partial_in});
        partial_out = '0;
      end else begin
        for (int i = 0; i < 7; i++) begin
          if (lane == 3'(i)) begin
            partial_out[8*i +: 8] = byte_fold;
          end
        end
      end
    end
  end

  // Byte count wraps at 256, as SipHash keeps only its low byte.
  assign length_out = length_in + 8'(byte_present);

endmodule

`default_nettype wire

// ===== hdl/ksh_finalize.sv =====
// ----------------------------------------------------------------------------
// ksh_finalize
// Builds the tail word, compresses it and runs the two finalization rounds.
// ----------------------------------------------------------------------------
`default_nettype none

module ksh_finalize (
  input  ksh_pkg::sip_state_t state_in,
  input  logic [55:0]         partial_in,
  input  logic [7:0]          length_in,
  output logic [31:0]         digest
);

  ksh_pkg::sip_state_t s_tail;
  ksh_pkg::sip_state_t s_done;
  logic [63:0]         hash;

  // Tail word: buffered bytes with the length in the top byte.
  always_comb begin
    s_tail    = ksh_pkg::sip_compress(state_in, {length_in, partial_in});
    s_tail.v2 = s_tail.v2 ^ 64'(ksh_pkg::FINAL_XOR);
    s_done    = ksh_pkg::sip_round(ksh_pkg::sip_round(s_tail));
  end

  assign hash   = s_done.v0 ^ s_done.v1 ^ s_done.v2 ^ s_done.v3;
  assign digest = hash[31:0];

endmodule

`default_nettype wire

// ===== hdl/keyed_siphash_stream_unit.sv =====
// ----------------------------------------------------------------------------
// keyed_siphash_stream_unit
// Keyed SipHash-1-2 over a byte stream, one byte per request, returning the
// low 32 bits of the hash on the last request of each message. The unit takes
// one request every clock cycle unless the input stalls; a request sits in the
// input register from the edge that accepts it, and its digest is loaded into
// the result register at the edge where the request moves on. A final request waits in the
// input register, stalling the input, while an earlier digest is held under
// out_stall. The clock period is set by the finalize path, which chains
// up to four SipRounds (word compression, tail compression and two
// finalization rounds) between the input register and the result register.
// An empty message is a single request with byte_present low and is_last high;
// a request with neither is dropped. Chaining state reloads from the key at the
// first request of every message, and fold_case maps A-Z to a-z before mixing.
// Users write registers via the cfg port only while idle; nothing checks it.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_siphash_stream_unit (
  input  logic        clk,
  input  logic        rst_n,
  // Byte stream
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_is_last,
  // Digest results
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest,
  // Register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  // Configuration registers
  logic [63:0] key_low_r;
  logic [63:0] key_high_r;
  logic        fold_case_r;

  // Input register
  logic        item_vld_r;
  logic        item_vld_nxt;
  logic [7:0]  item_byte_r;
  logic        item_present_r;
  logic        item_last_r;

  // Message state
  ksh_pkg::sip_state_t v_r;
  logic [55:0]         partial_r;
  logic [7:0]          length_r;
  logic                in_msg_r;

  // Result register
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [31:0] out_digest_r;

  // Processing path
  ksh_pkg::sip_state_t v_start;
  logic [55:0]         partial_start;
  logic [7:0]          length_start;
  ksh_pkg::sip_state_t v_abs;
  logic [55:0]         partial_abs;
  logic [7:0]          length_abs;
  logic [31:0]         digest_calc;

  logic in_take;
  logic out_free;
  logic advance;
  logic commit;

  // The register port never blocks.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r   <= '0;
      key_high_r  <= '0;
      fold_case_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ksh_pkg::REG_KEY_LOW:   key_low_r   <= cfg_wdata;
        ksh_pkg::REG_KEY_HIGH:  key_high_r  <= cfg_wdata;
        ksh_pkg::REG_FOLD_CASE: fold_case_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Handshake: a non-final request always moves on, a final one needs a free
  // result register.
  assign out_free = !out_valid_r || !out_stall;
  assign advance  = item_vld_r && (!item_last_r || out_free);
  assign commit   = advance && (item_present_r || item_last_r);
  assign in_stall = item_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;

  assign item_vld_nxt = in_take || (item_vld_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else begin
      item_vld_r <= item_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_byte_r    <= in_data_byte;
      item_present_r <= in_byte_present;
      item_last_r    <= in_is_last;
    end
  end

  // A new message starts from the key with an empty buffer.
  assign v_start       = in_msg_r ? v_r : ksh_pkg::sip_init(key_low_r, key_high_r);
  assign partial_start = in_msg_r ? partial_r : '0;
  assign length_start  = in_msg_r ? length_r : '0;

  ksh_absorb u_absorb (
    .state_in     (v_start),
    .partial_in   (partial_start),
    .length_in    (length_start),
    .data_byte    (item_byte_r),
    .byte_present (item_present_r),
    .fold_case    (fold_case_r),
    .state_out    (v_abs),
    .partial_out  (partial_abs),
    .length_out   (length_abs)
  );

  ksh_finalize u_finalize (
    .state_in   (v_abs),
    .partial_in (partial_abs),
    .length_in  (length_abs),
    .digest     (digest_calc)
  );

  // Message state updates on every request that carries a byte or ends a message.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_msg_r <= 1'b0;
    end else if (commit) begin
      in_msg_r <= !item_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      v_r       <= v_abs;
      partial_r <= partial_abs;
      length_r  <= length_abs;
    end
  end

  // Result register loads on a final request and empties when taken.
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (advance && item_last_r) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_last_r) begin
      out_digest_r <= digest_calc;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_digest = out_digest_r;

`ifndef SYNTHESIS
  // A final request closes the message.
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    commit && item_last_r |=> !in_msg_r)
    else $error("message still open after its final request");

  // A final request always leaves a digest in the result register.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    commit && item_last_r |=> out_valid_r)
    else $error("final request produced no digest");

  // A byte in mid-message advances the byte count by one.
  a_length_step: assert property (@(posedge clk) disable iff (!rst_n)
    commit && item_present_r && !item_last_r |=>
      (in_msg_r && (length_r == $past(length_start) + 8'd1)))
    else $error("byte count did not advance by one");
`endif

endmodule

`default_nettype wire
